// ----- rtl/hgsd_pkg.sv -----
package hgsd_pkg;

    // field widths
    localparam int COEF_W     = 32;
    localparam int NUM_COEF   = 9;
    localparam int BOX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int UPP_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int WORLD_FRAC = 16;

    // internal widths
    localparam int SUM_W       = 50;   // signed corner sum h*x + h*y + h
    localparam int WC_W        = 57;   // signed world coordinate, q.16
    localparam int DIFF_W      = 57;   // magnitude of a coordinate difference
    localparam int ACC_W       = 116;  // multiply-accumulate register
    localparam int MPL_W       = 57;   // serial multiplier operand
    localparam int CNT_W       = 6;
    localparam int ROOT_W      = 58;
    localparam int SQ_REM_W    = 61;
    localparam int DIV_NUM_W   = 65;
    localparam int DIV_DEN_W   = 49;
    localparam int DIV_CNT_W   = 7;
    localparam int RSUM_W      = 60;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO_DEN = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SAT      = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM = 3'd3;

    // register reset values
    localparam logic [BOX_W-1:0] BOX_LEFT_RST   = 16'd0;
    localparam logic [BOX_W-1:0] BOX_TOP_RST    = 16'd0;
    localparam logic [BOX_W-1:0] BOX_RIGHT_RST  = 16'd639;
    localparam logic [BOX_W-1:0] BOX_BOTTOM_RST = 16'd479;

    // one classified item as it waits in the queue
    typedef struct packed {
        logic [NUM_COEF-1:0][COEF_W-1:0] h;
        logic [BOX_W-1:0]                left;
        logic [BOX_W-1:0]                top;
        logic [BOX_W-1:0]                right;
        logic [BOX_W-1:0]                bottom;
        logic [BOX_W-1:0]                wpix;
        logic [BOX_W-1:0]                hpix;
        logic                            empty;
    } hgsd_item_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } hgsd_qstat_t;

endpackage

// ----- rtl/hgsd_front.sv -----
module hgsd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // h00, h01, h02, h10, h11, h12, h20, h21, h22 from bit 0 up, 32 bits each
    input  logic [hgsd_pkg::NUM_COEF*hgsd_pkg::COEF_W-1:0] s_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hgsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hgsd_pkg::BOX_W-1:0]          cfg_data,
    input  hgsd_pkg::hgsd_qstat_t               q_stat,
    output logic                                push,
    output hgsd_pkg::hgsd_item_t                push_item
);
    import hgsd_pkg::*;

    logic [BOX_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [BOX_W-1:0] wpix, hpix;

    // box registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= BOX_LEFT_RST;
            top_reg    <= BOX_TOP_RST;
            right_reg  <= BOX_RIGHT_RST;
            bottom_reg <= BOX_BOTTOM_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BOX_LEFT:   left_reg   <= cfg_data;
                REG_BOX_TOP:    top_reg    <= cfg_data;
                REG_BOX_RIGHT:  right_reg  <= cfg_data;
                REG_BOX_BOTTOM: bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // side lengths in pixels, order of bounds does not matter
    assign wpix = (right_reg >= left_reg) ? right_reg - left_reg : left_reg - right_reg;
    assign hpix = (bottom_reg >= top_reg) ? bottom_reg - top_reg : top_reg - bottom_reg;

    // accept and classify
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < NUM_COEF; i++) begin
            push_item.h[i] = s_tdata[i*COEF_W +: COEF_W];
        end
        push_item.left   = left_reg;
        push_item.top    = top_reg;
        push_item.right  = right_reg;
        push_item.bottom = bottom_reg;
        push_item.wpix   = wpix;
        push_item.hpix   = hpix;
        push_item.empty  = (wpix == '0) || (hpix == '0);
    end

endmodule

// ----- rtl/hgsd_fifo.sv -----
module hgsd_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  hgsd_pkg::hgsd_item_t  push_item,
    input  logic                  pop,
    output hgsd_pkg::hgsd_qstat_t q_stat,
    output hgsd_pkg::hgsd_item_t  head
);
    import hgsd_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    hgsd_item_t          mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign q_stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/hgsd_div.sv -----
module hgsd_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [hgsd_pkg::DIV_NUM_W-1:0]   num,
    input  logic [hgsd_pkg::DIV_DEN_W-1:0]   den,
    output logic                             busy,
    output logic                             done,
    output logic [hgsd_pkg::DIV_NUM_W-1:0]   quot
);
    import hgsd_pkg::*;

    logic                   busy_reg, done_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_DEN_W-1:0]   rem_reg, den_reg;
    logic [DIV_NUM_W-1:0]   nq_reg;
    logic [DIV_DEN_W:0]     r2;
    logic                   ge;

    // one restoring step: next numerator bit in, one quotient bit out
    assign r2 = {rem_reg, nq_reg[DIV_NUM_W-1]};
    assign ge = (r2 >= {1'b0, den_reg});

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = nq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            nq_reg  <= num;
        end else if (busy_reg) begin
            rem_reg <= ge ? DIV_DEN_W'(r2 - {1'b0, den_reg}) : r2[DIV_DEN_W-1:0];
            nq_reg  <= {nq_reg[DIV_NUM_W-2:0], ge};
        end
    end

endmodule

// ----- rtl/hgsd_sqrt.sv -----
module hgsd_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [hgsd_pkg::ACC_W-1:0]    op,
    output logic                          done,
    output logic [hgsd_pkg::ROOT_W-1:0]   root
);
    import hgsd_pkg::*;

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SQ_REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [ACC_W-1:0]     op_reg;
    logic [SQ_REM_W-1:0]  r2, trial;
    logic                 ge;

    // one root bit per step from two operand bits
    assign r2    = {rem_reg[SQ_REM_W-3:0], op_reg[ACC_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = (r2 >= trial);

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            root_reg <= '0;
            op_reg   <= op;
        end else if (busy_reg) begin
            rem_reg  <= ge ? r2 - trial : r2;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            op_reg   <= {op_reg[ACC_W-3:0], 2'b00};
        end
    end

endmodule

// ----- rtl/hgsd_back.sv -----
module hgsd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hgsd_pkg::hgsd_qstat_t          q_stat,
    input  hgsd_pkg::hgsd_item_t           head,
    output logic                           pop,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [hgsd_pkg::UPP_W-1:0]     res_units,
    output logic [hgsd_pkg::STATUS_W-1:0]  res_status
);
    import hgsd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_RDIV = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [1:0] PH_W  = 2'd0;
    localparam logic [1:0] PH_X  = 2'd1;
    localparam logic [1:0] PH_Y  = 2'd2;
    localparam logic [1:0] PH_SQ = 2'd3;

    localparam logic [CNT_W-1:0] CORNER_STEPS = CNT_W'(BOX_W);
    localparam logic [CNT_W-1:0] SQ_STEPS     = CNT_W'(DIFF_W);

    logic [2:0]              state_reg, state_next;
    logic [1:0]              phase_reg, phase_next;
    logic [1:0]              idx_reg, idx_next;
    logic                    half_reg, half_next;
    logic                    zero_reg, zero_next;
    logic                    sign_reg, sign_next;
    hgsd_item_t              item_reg, item_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [ACC_W-1:0]        mcand_reg, mcand_next;
    logic [MPL_W-1:0]        mplier_reg, mplier_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [RSUM_W-1:0]       sum_reg, sum_next;
    logic [UPP_W-1:0]        res_units_reg, res_units_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;

    logic signed [SUM_W-1:0] w_reg  [4];
    logic signed [WC_W-1:0]  wx_reg [4];
    logic signed [WC_W-1:0]  wy_reg [4];
    logic                    w_we, wx_we, wy_we;
    logic [WC_W-1:0]         wc_val;

    logic [COEF_W-1:0]       coef_mul, coef_add;
    logic [BOX_W-1:0]        cx, cy, pix;
    logic [WC_W-1:0]         wxa, wxb, wya, wyb;
    logic [WC_W:0]           dxs, dys;
    logic [DIFF_W-1:0]       dx, dy;
    logic [SUM_W-1:0]        acc_sum, w_cur;
    logic [SUM_W-1:0]        acc_abs, w_abs;
    logic [WC_W-1:0]         q_mag;
    logic [ROOT_W-1:0]       total;

    logic                    div_start, div_busy, div_done;
    logic [DIV_NUM_W-1:0]    div_num, div_quot;
    logic [DIV_DEN_W-1:0]    div_den;
    logic                    sq_start, sq_done;
    logic [ROOT_W-1:0]       sq_root;

    hgsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    hgsd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .op      (acc_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    // coefficient row for the current corner sum
    always_comb begin
        case (phase_reg)
            PH_X: begin
                coef_mul = half_reg ? item_reg.h[1] : item_reg.h[0];
                coef_add = item_reg.h[2];
            end
            PH_Y: begin
                coef_mul = half_reg ? item_reg.h[4] : item_reg.h[3];
                coef_add = item_reg.h[5];
            end
            default: begin
                coef_mul = half_reg ? item_reg.h[7] : item_reg.h[6];
                coef_add = item_reg.h[8];
            end
        endcase
    end

    // corner 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
    assign cx = idx_reg[0] ? item_reg.right  : item_reg.left;
    assign cy = idx_reg[1] ? item_reg.bottom : item_reg.top;

    // sides: top, right, left, bottom
    always_comb begin
        case (idx_reg)
            2'd0: begin
                wxa = wx_reg[0]; wxb = wx_reg[1]; wya = wy_reg[0]; wyb = wy_reg[1];
            end
            2'd1: begin
                wxa = wx_reg[1]; wxb = wx_reg[3]; wya = wy_reg[1]; wyb = wy_reg[3];
            end
            2'd2: begin
                wxa = wx_reg[0]; wxb = wx_reg[2]; wya = wy_reg[0]; wyb = wy_reg[2];
            end
            default: begin
                wxa = wx_reg[2]; wxb = wx_reg[3]; wya = wy_reg[2]; wyb = wy_reg[3];
            end
        endcase
    end

    assign dxs = {wxa[WC_W-1], wxa} - {wxb[WC_W-1], wxb};
    assign dys = {wya[WC_W-1], wya} - {wyb[WC_W-1], wyb};
    assign dx  = dxs[WC_W] ? DIFF_W'(-dxs) : dxs[DIFF_W-1:0];
    assign dy  = dys[WC_W] ? DIFF_W'(-dys) : dys[DIFF_W-1:0];
    assign pix = (idx_reg[0] ^ idx_reg[1]) ? item_reg.hpix : item_reg.wpix;

    // magnitudes for the perspective divide
    assign acc_sum = acc_reg[SUM_W-1:0];
    assign w_cur   = w_reg[idx_reg];
    assign acc_abs = acc_sum[SUM_W-1] ? -acc_sum : acc_sum;
    assign w_abs   = w_cur[SUM_W-1] ? -w_cur : w_cur;
    assign q_mag   = {1'b0, div_quot[WC_W-2:0]};
    assign wc_val  = sign_reg ? -q_mag : q_mag;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        half_next       = half_reg;
        zero_next       = zero_reg;
        sign_next       = sign_reg;
        item_next       = item_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        res_units_next  = res_units_reg;
        res_status_next = res_status_reg;
        total           = '0;
        pop             = 1'b0;
        w_we            = 1'b0;
        wx_we           = 1'b0;
        wy_we           = 1'b0;
        div_start       = 1'b0;
        div_num         = '0;
        div_den         = '0;
        sq_start        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    item_next  = head;
                    phase_next = PH_W;
                    idx_next   = '0;
                    half_next  = 1'b0;
                    zero_next  = 1'b0;
                    sum_next   = '0;
                    state_next = S_LOAD;
                end
            end

            // load operands of one product of the running sum
            S_LOAD: begin
                if (phase_reg == PH_SQ) begin
                    mcand_next  = ACC_W'(half_reg ? dy : dx);
                    mplier_next = half_reg ? dy : dx;
                    cnt_next    = SQ_STEPS;
                    if (!half_reg) acc_next = '0;
                end else begin
                    mcand_next  = {{(ACC_W-COEF_W){coef_mul[COEF_W-1]}}, coef_mul};
                    mplier_next = MPL_W'(half_reg ? cy : cx);
                    cnt_next    = CORNER_STEPS;
                    if (!half_reg) begin
                        acc_next = {{(ACC_W-COEF_W){coef_add[COEF_W-1]}}, coef_add};
                    end
                end
                state_next = S_MAC;
            end

            // shift-add, one multiplier bit per cycle
            S_MAC: begin
                if (mplier_reg[0]) acc_next = acc_reg + mcand_reg;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MPL_W-1:1]};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    if (!half_reg) begin
                        half_next  = 1'b1;
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_POST;
                    end
                end
            end

            S_POST: begin
                half_next = 1'b0;
                case (phase_reg)
                    PH_W: begin
                        w_we      = 1'b1;
                        zero_next = zero_reg || (acc_sum == '0);
                        if (idx_reg == 2'd3) begin
                            if (zero_next) begin
                                res_units_next  = '0;
                                res_status_next = STAT_ZERO_DEN;
                                state_next      = S_DONE;
                            end else if (item_reg.empty) begin
                                res_units_next  = '0;
                                res_status_next = STAT_EMPTY;
                                state_next      = S_DONE;
                            end else begin
                                phase_next = PH_X;
                                idx_next   = '0;
                                state_next = S_LOAD;
                            end
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_LOAD;
                        end
                    end
                    PH_SQ: begin
                        sq_start   = 1'b1;
                        state_next = S_SQRT;
                    end
                    default: begin
                        div_start  = 1'b1;
                        div_num    = {acc_abs[DIV_DEN_W-1:0], {WORLD_FRAC{1'b0}}};
                        div_den    = w_abs[DIV_DEN_W-1:0];
                        sign_next  = acc_sum[SUM_W-1] ^ w_cur[SUM_W-1];
                        state_next = S_DIV;
                    end
                endcase
            end

            // world coordinate done
            S_DIV: begin
                if (div_done) begin
                    if (div_quot[DIV_NUM_W-1:WC_W-1] != '0) begin
                        res_units_next  = '1;
                        res_status_next = STAT_SAT;
                        state_next      = S_DONE;
                    end else if (phase_reg == PH_X) begin
                        wx_we      = 1'b1;
                        phase_next = PH_Y;
                        state_next = S_LOAD;
                    end else begin
                        wy_we      = 1'b1;
                        state_next = S_LOAD;
                        if (idx_reg == 2'd3) begin
                            phase_next = PH_SQ;
                            idx_next   = '0;
                        end else begin
                            phase_next = PH_X;
                            idx_next   = idx_reg + 1'b1;
                        end
                    end
                end
            end

            // world length over pixel length
            S_SQRT: begin
                if (sq_done) begin
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'(sq_root);
                    div_den    = DIV_DEN_W'(pix);
                    state_next = S_RDIV;
                end
            end

            S_RDIV: begin
                if (div_done) begin
                    sum_next = sum_reg + RSUM_W'(div_quot[ROOT_W-1:0]);
                    if (idx_reg == 2'd3) begin
                        total = sum_next[RSUM_W-1:2];
                        if (total[ROOT_W-1:UPP_W] != '0) begin
                            res_units_next  = '1;
                            res_status_next = STAT_SAT;
                        end else begin
                            res_units_next  = total[UPP_W-1:0];
                            res_status_next = STAT_OK;
                        end
                        state_next = S_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end

            S_DONE: begin
                if (res_ready) state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign res_valid  = (state_reg == S_DONE);
    assign res_units  = res_units_reg;
    assign res_status = res_status_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_W;
            idx_reg   <= '0;
            half_reg  <= 1'b0;
            zero_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            half_reg  <= half_next;
            zero_reg  <= zero_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sign_reg       <= sign_next;
        item_reg       <= item_next;
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        cnt_reg        <= cnt_next;
        sum_reg        <= sum_next;
        res_units_reg  <= res_units_next;
        res_status_reg <= res_status_next;
        if (w_we)  w_reg[idx_reg]  <= acc_sum;
        if (wx_we) wx_reg[idx_reg] <= wc_val;
        if (wy_we) wy_reg[idx_reg] <= wc_val;
    end

    a_mac_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MAC |-> cnt_reg != '0)
        else $error("multiply step with exhausted count");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_zero_den_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_status_reg == STAT_ZERO_DEN) |-> res_units_reg == '0)
        else $error("zero denominator result carries nonzero units");

    a_pop_start: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg == S_LOAD && phase_reg == PH_W && idx_reg == '0))
        else $error("new item did not start with the denominator sums");

endmodule

// ----- rtl/homography_ground_sample_distance_unit.sv -----
// Ground sample distance from an image-to-world homography.
// Input channel (s_): one item is one 3x3 homography, nine signed Q16.16
// coefficients in row-major order. Output channel (m_): one result per item,
// world units per pixel in unsigned Q16.16 on m_tdata and a status code on
// m_tuser (ok, zero perspective denominator, empty box side, saturated).
// Config channel (cfg_): box_left, box_top, box_right, box_bottom at
// indexes 0 to 3; other indexes are ignored. Write only while idle.
// A front end accepts items into a two-entry queue; a back end projects
// the four box corners and measures the four sides using one shared
// bit-serial multiply-accumulate, one 65-step divider and one 58-step
// square root unit. The back end works on one item at a time and so sets
// the throughput; an item with a zero denominator or an empty box side
// leaves it after the denominator sums. Up to two further items are taken
// while one is worked on.
// The result waits in an output register while m_tready is low; the back
// end then holds its next result until the register is free.
// Reset (aresetn low, synchronous) empties the queue and output register
// and sets the box to columns 0..639, rows 0..479.
module homography_ground_sample_distance_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // h00, h01, h02, h10, h11, h12, h20, h21, h22 from bit 0 up, 32 bits each
    input  logic [hgsd_pkg::NUM_COEF*hgsd_pkg::COEF_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // units_per_pixel
    output logic [hgsd_pkg::UPP_W-1:0]          m_tdata,
    // status
    output logic [hgsd_pkg::STATUS_W-1:0]       m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hgsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hgsd_pkg::BOX_W-1:0]          cfg_data
);
    import hgsd_pkg::*;

    hgsd_qstat_t          q_stat;
    hgsd_item_t           push_item, head;
    logic                 push, pop;
    logic                 res_valid, res_ready;
    logic [UPP_W-1:0]     res_units;
    logic [STATUS_W-1:0]  res_status;
    logic                 out_valid_reg;
    logic [UPP_W-1:0]     out_units_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    hgsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    hgsd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_stat    (q_stat),
        .head      (head)
    );

    hgsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_units  (res_units),
        .res_status (res_status)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_units_reg  <= res_units;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_units_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hgsd_pkg::*;

    localparam int                   ITEM_W     = NUM_COEF * COEF_W;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOPIDX = 3'd7;
    localparam int                   SETTLE     = 20;

    typedef logic [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic [UPP_W-1:0]    upp;
        logic [STATUS_W-1:0] status;
    } gsd_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [ITEM_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [UPP_W-1:0]      m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [BOX_W-1:0]      cfg_data  = '0;

    // box as the block should hold it
    logic [BOX_W-1:0] box_l = BOX_LEFT_RST;
    logic [BOX_W-1:0] box_t = BOX_TOP_RST;
    logic [BOX_W-1:0] box_r = BOX_RIGHT_RST;
    logic [BOX_W-1:0] box_b = BOX_BOTTOM_RST;

    logic [ITEM_W-1:0] homog_pending[$];
    gsd_t              gsd_expected[$];
    int                send_gap  = 0;
    int                stall_cnt = 0;
    int                errors    = 0;
    bit                no_idle   = 1'b0;

    homography_ground_sample_distance_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, long_max);
    endfunction

    // signed q.16 world coordinate num/den, flags a huge integer part
    function automatic longint world_div(longint num, longint den, ref bit sat);
        longint unsigned a, d;
        logic [127:0]    m;
        a = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (a / d >= (64'd1 << 40)) begin
            sat = 1'b1;
            return 0;
        end
        m = ({64'd0, a} << WORLD_FRAC) / d;
        return ((num < 0) != (den < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    // floor of the euclidean length of a difference vector
    function automatic longint unsigned side_len(longint a0, longint a1,
                                                 longint b0, longint b1);
        logic [127:0] dx, dy, sq, cand;
        logic [63:0]  root;
        dx = (a0 > a1) ? a0 - a1 : a1 - a0;
        dy = (b0 > b1) ? b0 - b1 : b1 - b0;
        sq = dx * dx + dy * dy;
        root = '0;
        for (int b = 59; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= sq) root = cand[63:0];
        end
        return root;
    endfunction

    // ground sample distance of one homography with the current box
    function automatic gsd_t predict_gsd(logic [ITEM_W-1:0] d);
        longint          hc[9];
        longint          cx[4], cy[4], wx[4], wy[4];
        longint          nz;
        longint unsigned wpix, hpix;
        logic [127:0]    total;
        bit              sat;
        gsd_t            res;
        sat = 1'b0;
        for (int i = 0; i < 9; i++) hc[i] = longint'(signed'(d[i*COEF_W +: COEF_W]));
        cx[0] = box_l; cy[0] = box_t;
        cx[1] = box_r; cy[1] = box_t;
        cx[2] = box_l; cy[2] = box_b;
        cx[3] = box_r; cy[3] = box_b;
        // zero perspective denominator wins over everything
        for (int i = 0; i < 4; i++) begin
            if (hc[6] * cx[i] + hc[7] * cy[i] + hc[8] == 0) begin
                res.upp = '0;
                res.status = STAT_ZERO_DEN;
                return res;
            end
        end
        wpix = (box_r >= box_l) ? box_r - box_l : box_l - box_r;
        hpix = (box_b >= box_t) ? box_b - box_t : box_t - box_b;
        if (wpix == 0 || hpix == 0) begin
            res.upp = '0;
            res.status = STAT_EMPTY;
            return res;
        end
        for (int i = 0; i < 4; i++) begin
            nz = hc[6] * cx[i] + hc[7] * cy[i] + hc[8];
            wx[i] = world_div(hc[0] * cx[i] + hc[1] * cy[i] + hc[2], nz, sat);
            wy[i] = world_div(hc[3] * cx[i] + hc[4] * cy[i] + hc[5], nz, sat);
        end
        if (sat) begin
            res.upp = '1;
            res.status = STAT_SAT;
            return res;
        end
        // top, right, left, bottom
        total = side_len(wx[0], wx[1], wy[0], wy[1]) / wpix
              + side_len(wx[1], wx[3], wy[1], wy[3]) / hpix
              + side_len(wx[0], wx[2], wy[0], wy[2]) / hpix
              + side_len(wx[2], wx[3], wy[2], wy[3]) / wpix;
        total = total >> 2;
        if (total > 128'hFFFF_FFFF) begin
            res.upp = '1;
            res.status = STAT_SAT;
        end else begin
            res.upp = total[UPP_W-1:0];
            res.status = STAT_OK;
        end
        return res;
    endfunction

    // driver: predicts each accepted item, then presents the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) gsd_expected.push_back(predict_gsd(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (homog_pending.size() > 0) begin
                    s_tdata  <= homog_pending.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(300);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge aclk) begin
        gsd_t exp_res;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (gsd_expected.size() == 0) begin
                    $display("%0t: unexpected result upp=%h status=%0d",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    exp_res = gsd_expected.pop_front();
                    if (m_tdata !== exp_res.upp) begin
                        $display("%0t: units_per_pixel expected %h actual %h",
                                 $time, exp_res.upp, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, m_tuser);
                        errors++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_tready <= 1'b0;
            end else begin
                stall_cnt = pick_gap(2500);
                m_tready <= (stall_cnt == 0);
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BOX_LEFT:   box_l = val;
            REG_BOX_TOP:    box_t = val;
            REG_BOX_RIGHT:  box_r = val;
            REG_BOX_BOTTOM: box_b = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (homog_pending.size() > 0 || s_tvalid || gsd_expected.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_box(int l, int t, int r, int b);
        wait_idle();
        cfg_write(REG_BOX_LEFT, BOX_W'(l));
        cfg_write(REG_BOX_TOP, BOX_W'(t));
        cfg_write(REG_BOX_RIGHT, BOX_W'(r));
        cfg_write(REG_BOX_BOTTOM, BOX_W'(b));
    endtask

    task automatic add_homog(coef_t c[9]);
        logic [ITEM_W-1:0] d;
        for (int i = 0; i < 9; i++) d[i*COEF_W +: COEF_W] = c[i];
        homog_pending.push_back(d);
    endtask

    function automatic coef_t smallsigned(int unsigned lo, int unsigned hi);
        coef_t v;
        v = $urandom_range(lo, hi);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // mostly plausible camera homographies, plus raw and corner-case noise
    task automatic add_random();
        coef_t c[9];
        int    kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++) c[i] = $urandom;
        if (kind < 55) begin
            c[0] = smallsigned(1 << 8, 1 << 20);
            c[1] = smallsigned(0, 1 << 14);
            c[3] = smallsigned(0, 1 << 14);
            c[4] = smallsigned(1 << 8, 1 << 20);
            c[6] = smallsigned(0, 64);
            c[7] = smallsigned(0, 64);
            c[8] = smallsigned(1 << 12, 1 << 24);
        end else if (kind < 65) begin
            c[6] = 0;
            c[7] = 0;
            c[8] = 0;
        end else if (kind < 72) begin
            // zero denominator at the right column only
            c[6] = 1;
            c[7] = 0;
            c[8] = -coef_t'(box_r);
        end else if (kind < 85) begin
            c[6] = 0;
            c[7] = 0;
            c[8] = smallsigned(1, 4);
            c[0] = smallsigned(1 << 20, 1 << 31);
            c[4] = smallsigned(1 << 20, 1 << 31);
        end else if (kind < 93) begin
            for (int i = 0; i < 9; i++) begin
                case ($urandom_range(0, 3))
                    0: c[i] = 32'h8000_0000;
                    1: c[i] = 32'h7FFF_FFFF;
                    2: c[i] = 0;
                    default: ;
                endcase
            end
        end
        add_homog(c);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) add_random();
        wait_idle();
    endtask

    // stimulus
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed at the reset box
        add_homog('{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000});
        add_homog('{32'hFFFF0000, 0, 32'h12345678, 0, 32'hFFFE0000, 0, 0, 0, 32'h10000});
        add_homog('{default: 32'h0});
        add_homog('{default: 32'h7FFFFFFF});
        add_homog('{default: 32'h80000000});
        add_homog('{32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h1});
        add_homog('{32'h10000, 0, 0, 0, 32'h10000, 0, 1, 0, -32'd639});
        add_homog('{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 1, -32'd479});
        add_homog('{32'h10000, 32'h100, 32'h7FFFFFFF, 32'h200, 32'h10000,
                    32'h80000000, 32'h10, 32'hFFFFFFF0, 32'h100000});
        add_homog('{32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'hFFFF0000});
        // hold off until every result is in
        wait_idle();

        // tiny box: overflow of the mean
        set_box(0, 0, 1, 1);
        add_homog('{32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h1});
        add_homog('{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000});
        // empty width and empty height
        set_box(7, 3, 7, 100);
        add_homog('{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000});
        add_homog('{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h0});
        set_box(0, 5, 10, 5);
        add_homog('{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000});
        // ignored indexes leave the box alone
        wait_idle();
        cfg_write(REG_SPARE, 16'hFFFF);
        cfg_write(REG_TOPIDX, 16'h1234);
        add_homog('{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000});
        wait_idle();

        // random phases over a range of boxes
        set_box(0, 0, 639, 479);
        run_random(70);
        no_idle = 1'b1;
        set_box(0, 0, 65535, 65535);
        run_random(50);
        no_idle = 1'b0;
        set_box(639, 479, 0, 0);
        run_random(60);
        set_box(65535, 65535, 0, 0);
        run_random(40);
        set_box(0, 0, 1, 1);
        run_random(40);
        set_box(12, 40, 12, 200);
        run_random(20);
        for (int p = 0; p < 5; p++) begin
            set_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
            run_random(34);
        end

        wait_idle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
